[rtl/core/assert_macros.svh]
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sorted table check failed");
`define STI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sorted table check failed");
`else
`define STI_ASSERT(lbl, prop)
`define STI_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/core/sti_pkg.sv]
package sti_pkg;

  localparam int DEPTH     = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int WORD_W    = 32;
  localparam int OUT_CNT_W = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    REG_INITIAL_FIRST  = 1'b0,
    REG_INITIAL_SECOND = 1'b1
  } reg_idx_t;

  localparam word_t RST_INITIAL_FIRST  = 32'sd2;
  localparam word_t RST_INITIAL_SECOND = 32'sd4;

  typedef struct packed {
    logic  step;
    logic  load;
    logic  found;
    op_t   op;
    word_t value;
  } cell_ctl_t;

endpackage

[rtl/core/sti_if.sv]
interface sti_in_if;
  import sti_pkg::*;
  logic  valid;
  logic  ready;
  op_t   req_type;
  word_t item_value;
  modport source (output valid, req_type, item_value, input ready);
  modport sink (input valid, req_type, item_value, output ready);
endinterface

interface sti_out_if;
  import sti_pkg::*;
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [OUT_CNT_W-1:0] entry_count;
  word_t                smallest_value;
  word_t                largest_value;
  modport source (output valid, status, entry_count, smallest_value, largest_value,
                  input ready);
  modport sink (input valid, status, entry_count, smallest_value, largest_value,
                output ready);
endinterface

interface sti_cfg_if;
  import sti_pkg::*;
  logic     valid;
  logic     ready;
  reg_idx_t index;
  word_t    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/sti_cell.sv]
module sti_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sti_pkg::cell_ctl_t ctl,
  input  sti_pkg::word_t    ld_word,
  input  logic              ld_occ,
  input  sti_pkg::word_t    left_word,
  input  logic              left_occ,
  input  logic              left_lt,
  input  sti_pkg::word_t    right_word,
  input  logic              right_occ,
  output sti_pkg::word_t    word,
  output logic              occ,
  output logic              lt,
  output logic              match
);
  import sti_pkg::*;

  word_t word_r, word_nxt;
  logic  occ_r, occ_nxt;

  always_comb begin
    lt    = occ_r && (word_r < ctl.value);
    // first equal entry: the one before it is smaller
    match = occ_r && (word_r == ctl.value) && left_lt;
  end

  always_comb begin
    word_nxt = word_r;
    occ_nxt  = occ_r;
    if (ctl.load) begin
      word_nxt = ld_word;
      occ_nxt  = ld_occ;
    end else if (ctl.step) begin
      case (ctl.op)
        OP_INSERT: begin
          if (!lt) begin
            word_nxt = left_lt ? ctl.value : left_word;
            occ_nxt  = occ_r | left_occ;
          end
        end
        OP_REMOVE: begin
          if (ctl.found && !lt) begin
            word_nxt = right_word;
            occ_nxt  = right_occ;
          end
        end
        default: begin
          word_nxt = word_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= ld_word;
      occ_r  <= ld_occ;
    end else begin
      word_r <= word_nxt;
      occ_r  <= occ_nxt;
    end
  end

  assign word = word_r;
  assign occ  = occ_r;

endmodule

[rtl/core/sorted_table_insert_remove_unit.sv]
// sorted table engine: keeps up to DEPTH signed 32-bit words in ascending order
// in_if   : request word (req_type insert/remove, item_value), valid/ready
// out_if  : one result word per request: status, entry_count, smallest_value,
//           largest_value (both 0 when the table is empty)
// cfg_if  : register writes (index 0 initial_first, 1 initial_second); any write
//           reloads the table with the two values in order and count 2
// the table is a row of cells, one entry each; every cell compares its entry
// with the request value and shifts from its left or right neighbor, so an
// insert or remove completes in the cycle the request is accepted
// the result is registered in the staging register at acceptance and moves to the
// output register when that is free; out_if.valid rises once it gets there
// a new request is taken only after the staging register has passed its result on;
// in_if.ready is low while a result is waiting to be staged
// a stalled receiver holds the output register; one more request may be taken
// and its result held in staging until the output frees up
// reset: table holds 2 and 4, count 2, no result pending
`include "assert_macros.svh"

module sorted_table_insert_remove_unit (
  input logic       clk,
  input logic       rst_n,
  sti_in_if.sink    in_if,
  sti_out_if.source out_if,
  sti_cfg_if.sink   cfg_if
);
  import sti_pkg::*;

  word_t            first_r, second_r;
  word_t            first_nxt, second_nxt;
  word_t            ld_lo, ld_hi;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r;
  status_t          pend_st_r, st_nxt;
  logic             out_valid_r;
  status_t          out_st_r;
  logic [CNT_W-1:0] out_cnt_r;
  word_t            out_small_r, out_large_r;
  word_t            small_nxt, large_nxt;

  logic             cfg_wr, acc, full, found, res_go;
  cell_ctl_t        ctl;

  word_t            cell_word [DEPTH];
  logic [DEPTH-1:0] occ, lt, match;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;
  assign in_if.ready  = !pend_r;
  assign acc          = in_if.valid && in_if.ready;
  assign full         = (count_r == CNT_W'(DEPTH));
  assign found        = |match;
  assign res_go       = pend_r && (!out_valid_r || out_if.ready);

  // register decode and reload pair
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    if (!rst_n) begin
      first_nxt  = RST_INITIAL_FIRST;
      second_nxt = RST_INITIAL_SECOND;
    end else if (cfg_wr) begin
      unique case (cfg_if.index)
        REG_INITIAL_FIRST:  first_nxt  = cfg_if.data;
        REG_INITIAL_SECOND: second_nxt = cfg_if.data;
      endcase
    end
    if (second_nxt < first_nxt) begin
      ld_lo = second_nxt;
      ld_hi = first_nxt;
    end else begin
      ld_lo = first_nxt;
      ld_hi = second_nxt;
    end
  end

  always_comb begin
    ctl.step  = acc && !((in_if.req_type == OP_INSERT) && full);
    ctl.load  = cfg_wr;
    ctl.found = found;
    ctl.op    = in_if.req_type;
    ctl.value = in_if.item_value;
  end

  always_comb begin
    count_nxt = count_r;
    st_nxt    = pend_st_r;
    if (cfg_wr) begin
      count_nxt = CNT_W'(2);
    end else if (acc) begin
      case (in_if.req_type)
        OP_INSERT: begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            st_nxt    = ST_INSERTED;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (found) begin
            st_nxt    = ST_REMOVED;
            count_nxt = count_r - CNT_W'(1);
          end else begin
            st_nxt = ST_NOT_FOUND;
          end
        end
        default: begin
          st_nxt = pend_st_r;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lw, rw;
    logic  lo, ll, ro;
    word_t ldw;

    assign ldw = (i == 0) ? ld_lo : ((i == 1) ? ld_hi : '0);
    assign lw  = (i == 0) ? '0 : cell_word[(i == 0) ? 0 : i - 1];
    assign lo  = (i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i - 1];
    assign ll  = (i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1];
    assign rw  = (i == DEPTH - 1) ? '0 : cell_word[(i == DEPTH - 1) ? i : i + 1];
    assign ro  = (i == DEPTH - 1) ? 1'b0 : occ[(i == DEPTH - 1) ? i : i + 1];

    sti_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ld_word   (ldw),
      .ld_occ    (i < 2),
      .left_word (lw),
      .left_occ  (lo),
      .left_lt   (ll),
      .right_word(rw),
      .right_occ (ro),
      .word      (cell_word[i]),
      .occ       (occ[i]),
      .lt        (lt[i]),
      .match     (match[i])
    );
  end

  // last occupied cell gives the largest entry
  always_comb begin
    small_nxt = occ[0] ? cell_word[0] : '0;
    large_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (occ[i] && ((i == DEPTH - 1) || !occ[(i == DEPTH - 1) ? i : i + 1])) begin
        large_nxt = large_nxt | cell_word[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= RST_INITIAL_FIRST;
      second_r    <= RST_INITIAL_SECOND;
      count_r     <= CNT_W'(2);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      count_r  <= count_nxt;
      if (acc) begin
        pend_r <= 1'b1;
      end else if (res_go) begin
        pend_r <= 1'b0;
      end
      if (res_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_st_r <= st_nxt;
    if (res_go) begin
      out_st_r    <= pend_st_r;
      out_cnt_r   <= count_r;
      out_small_r <= small_nxt;
      out_large_r <= large_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_st_r;
  assign out_if.entry_count    = OUT_CNT_W'(out_cnt_r);
  assign out_if.smallest_value = out_small_r;
  assign out_if.largest_value  = out_large_r;

  `STI_ASSERT(a_count_range, count_r <= CNT_W'(DEPTH))
  `STI_ASSERT(a_occ_matches_count, $countones(occ) == count_r)
  `STI_ASSERT(a_single_match, $onehot0(match))
  `STI_ASSERT_NEXT(a_reload_count, cfg_wr, (count_r == CNT_W'(2)) && occ[0] && occ[1])

endmodule
